>>> rtl/core/tag_count_table_with_resend_unit_assert.svh
// assertion macros for the tag count table with resend unit
`ifndef TAG_COUNT_TABLE_WITH_RESEND_UNIT_ASSERT_SVH
`define TAG_COUNT_TABLE_WITH_RESEND_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// checked property, off while reset is asserted
`define TCTR_ASSERT(NAME, CLK, RSTN, PROP) \
	NAME: assert property (@(posedge CLK) disable iff (!RSTN) PROP) \
		else $error("assertion failed");
// checked property, also checked during reset
`define TCTR_ASSERT_NORST(NAME, CLK, PROP) \
	NAME: assert property (@(posedge CLK) PROP) \
		else $error("assertion failed");
`else
`define TCTR_ASSERT(NAME, CLK, RSTN, PROP)
`define TCTR_ASSERT_NORST(NAME, CLK, PROP)
`endif
`endif

>>> rtl/core/tctr_pkg.sv
// shared types and constants of the tag count table with resend unit
`timescale 1ns / 1ps
`default_nettype none
package tctr_pkg;

	localparam int SLOTS   = 16;
	localparam int MAX_OUT = 16;
	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(MAX_OUT + 1);
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [3:0] CREDIT_RST = 4'd3;

	localparam logic [1:0] CMD_INC   = 2'd0;
	localparam logic [1:0] CMD_DUMP  = 2'd1;
	localparam logic [1:0] CMD_ACK   = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] KIND_COUNT = 2'd0;
	localparam logic [1:0] KIND_FULL  = 2'd1;
	localparam logic [1:0] KIND_DUMP  = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// decoded operation, one bit per command
	typedef struct packed {
		logic inc;
		logic dump;
		logic ack;
		logic clr;
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] tag_id;
		logic [15:0] amount;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] tag_id;
		logic [15:0] count;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/core/tctr_front.sv
// front end: input accept, command decode and item queue
`timescale 1ns / 1ps
`default_nettype none
`include "tag_count_table_with_resend_unit_assert.svh"
module tctr_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           cmd,
	input  wire logic [15:0]          tag_id,
	input  wire logic [15:0]          amount,
	output logic                      q_valid,
	output tctr_pkg::item_t           q_item,
	input  wire logic                 q_pop
);

	tctr_pkg::item_t                     mem_q [tctr_pkg::Q_DEPTH];
	logic [tctr_pkg::Q_PTR_W-1:0]        wr_ptr_q;
	logic [tctr_pkg::Q_PTR_W-1:0]        rd_ptr_q;
	logic [tctr_pkg::Q_CNT_W-1:0]        count_q;
	logic                                push;
	tctr_pkg::op_t                       op;

	always_comb begin
		op = '0;
		case (cmd)
			tctr_pkg::CMD_INC:   op.inc  = 1'b1;
			tctr_pkg::CMD_DUMP:  op.dump = 1'b1;
			tctr_pkg::CMD_ACK:   op.ack  = 1'b1;
			tctr_pkg::CMD_CLEAR: op.clr  = 1'b1;
			default:             op.clr  = 1'b1;
		endcase
	end

	assign in_stall = (count_q == tctr_pkg::Q_CNT_W'(tctr_pkg::Q_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{op: op, tag_id: tag_id, amount: amount};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == tctr_pkg::Q_PTR_W'(tctr_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == tctr_pkg::Q_PTR_W'(tctr_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`TCTR_ASSERT_NORST(a_queue_bound, clk, count_q <= tctr_pkg::Q_CNT_W'(tctr_pkg::Q_DEPTH))

endmodule
`default_nettype wire

>>> rtl/core/tctr_back.sv
// back end: slot table, scan sequencer and output register
`timescale 1ns / 1ps
`default_nettype none
`include "tag_count_table_with_resend_unit_assert.svh"
module tctr_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [3:0]           resend_credit,
	input  wire logic                 q_valid,
	input  wire tctr_pkg::item_t      q_item,
	output logic                      q_pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output tctr_pkg::result_t         out_res
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                         state_q;
	logic [15:0]                    slot_tag_q    [tctr_pkg::SLOTS];
	logic [15:0]                    slot_count_q  [tctr_pkg::SLOTS];
	logic [3:0]                     slot_credit_q [tctr_pkg::SLOTS];
	logic [tctr_pkg::SLOTS-1:0]     slot_inpay_q;

	tctr_pkg::op_t                  op_q;
	logic [15:0]                    tag_q;
	logic [15:0]                    amt_q;
	logic [tctr_pkg::IDX_W-1:0]     idx_q;
	logic                           match_q;
	logic [tctr_pkg::IDX_W-1:0]     match_idx_q;
	logic [15:0]                    match_cnt_q;
	logic                           empty_q;
	logic [tctr_pkg::IDX_W-1:0]     empty_idx_q;
	logic                           held_q;
	logic [15:0]                    held_tag_q;
	logic [15:0]                    held_cnt_q;
	logic [tctr_pkg::CNT_W-1:0]     n_q;

	logic                           out_valid_q;
	tctr_pkg::result_t              out_res_q;

	logic                           out_free;
	logic                           scan_hit;
	logic                           scan_stall;
	logic                           ld_en;
	tctr_pkg::result_t              ld_res;
	tctr_pkg::result_t              fin_res;
	logic [15:0]                    inc_sum;

	assign out_free   = !out_valid_q || !out_stall;
	assign scan_hit   = op_q.dump && (slot_credit_q[idx_q] != 4'd0) &&
		(n_q < tctr_pkg::CNT_W'(tctr_pkg::MAX_OUT));
	assign scan_stall = scan_hit && held_q && !out_free;
	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign inc_sum    = match_cnt_q + amt_q;

	always_comb begin
		fin_res = '{kind: tctr_pkg::KIND_NONE, tag_id: 16'd0, count: 16'd0, last: 1'b1};
		if (op_q.inc) begin
			if (match_q) begin
				fin_res = '{kind: tctr_pkg::KIND_COUNT, tag_id: tag_q, count: inc_sum,
					last: 1'b1};
			end else if (empty_q) begin
				fin_res = '{kind: tctr_pkg::KIND_COUNT, tag_id: tag_q, count: amt_q,
					last: 1'b1};
			end else begin
				fin_res = '{kind: tctr_pkg::KIND_FULL, tag_id: tag_q, count: 16'd0,
					last: 1'b1};
			end
		end else if (op_q.dump && held_q) begin
			fin_res = '{kind: tctr_pkg::KIND_DUMP, tag_id: held_tag_q, count: held_cnt_q,
				last: 1'b1};
		end
	end

	always_comb begin
		ld_en  = 1'b0;
		ld_res = '{kind: tctr_pkg::KIND_DUMP, tag_id: held_tag_q, count: held_cnt_q,
			last: 1'b0};
		case (state_q)
			ST_SCAN: ld_en = scan_hit && held_q && out_free;
			ST_FIN: begin
				ld_en  = out_free;
				ld_res = fin_res;
			end
			default: ld_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			for (int i = 0; i < tctr_pkg::SLOTS; i++) begin
				slot_tag_q[i]    <= 16'd0;
				slot_count_q[i]  <= 16'd0;
				slot_credit_q[i] <= tctr_pkg::CREDIT_RST;
			end
			slot_inpay_q <= '0;
			op_q         <= '0;
			tag_q        <= 16'd0;
			amt_q        <= 16'd0;
			idx_q        <= '0;
			match_q      <= 1'b0;
			match_idx_q  <= '0;
			match_cnt_q  <= 16'd0;
			empty_q      <= 1'b0;
			empty_idx_q  <= '0;
			held_q       <= 1'b0;
			held_tag_q   <= 16'd0;
			held_cnt_q   <= 16'd0;
			n_q          <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						op_q    <= q_item.op;
						tag_q   <= q_item.tag_id;
						amt_q   <= q_item.amount;
						idx_q   <= '0;
						match_q <= 1'b0;
						empty_q <= 1'b0;
						held_q  <= 1'b0;
						n_q     <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!scan_stall) begin
						if (op_q.inc) begin
							if (!match_q && slot_tag_q[idx_q] == tag_q) begin
								match_q     <= 1'b1;
								match_idx_q <= idx_q;
								match_cnt_q <= slot_count_q[idx_q];
							end
							if (!empty_q && slot_tag_q[idx_q] == 16'd0) begin
								empty_q     <= 1'b1;
								empty_idx_q <= idx_q;
							end
						end
						if (scan_hit) begin
							held_q              <= 1'b1;
							held_tag_q          <= slot_tag_q[idx_q];
							held_cnt_q          <= slot_count_q[idx_q];
							n_q                 <= n_q + 1'b1;
							slot_inpay_q[idx_q] <= 1'b1;
						end
						if (op_q.ack && slot_inpay_q[idx_q]) begin
							slot_inpay_q[idx_q] <= 1'b0;
							if (slot_credit_q[idx_q] != 4'd0) begin
								slot_credit_q[idx_q] <= slot_credit_q[idx_q] - 4'd1;
							end
						end
						if (op_q.clr) begin
							slot_tag_q[idx_q]    <= 16'd0;
							slot_count_q[idx_q]  <= 16'd0;
							slot_credit_q[idx_q] <= resend_credit;
							slot_inpay_q[idx_q]  <= 1'b0;
						end
						if (idx_q == tctr_pkg::IDX_W'(tctr_pkg::SLOTS - 1)) begin
							state_q <= ST_FIN;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						held_q  <= 1'b0;
						if (op_q.inc && match_q) begin
							slot_count_q[match_idx_q]  <= inc_sum;
							slot_credit_q[match_idx_q] <= resend_credit;
						end else if (op_q.inc && empty_q) begin
							slot_tag_q[empty_idx_q]    <= tag_q;
							slot_count_q[empty_idx_q]  <= amt_q;
							slot_credit_q[empty_idx_q] <= resend_credit;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register decouples the scan from a stalled receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_en) begin
			out_res_q <= ld_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`TCTR_ASSERT(a_only_dump_not_last, clk, arst_n, out_valid_q && (out_res_q.kind != tctr_pkg::KIND_DUMP) |-> out_res_q.last)
	`TCTR_ASSERT(a_idle_nothing_held, clk, arst_n, (state_q == ST_IDLE) |-> !held_q)
	`TCTR_ASSERT(a_pop_starts_scan, clk, arst_n, q_pop |=> (state_q == ST_SCAN) && (idx_q == '0))

endmodule
`default_nettype wire

>>> rtl/core/tag_count_table_with_resend_unit.sv
// top level of the tag count table with resend unit
// Counts tag reads in a table of tctr_pkg::SLOTS slots and reports changed slots in dumps.
// A front queue of two items takes commands while the back end works; the back end
// scans the table one slot per cycle while the output side does not stall: it takes
// the item, visits each slot in turn and then loads the closing result. A dump emits
// one result per slot with nonzero credit (at most MAX_OUT), flagging the final one
// with last; increment returns the new count or table full; acknowledge and clear
// return one done result. The user is to write the resend credit register through
// cfg_wen/cfg_wdata only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module tag_count_table_with_resend_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write
	input  wire logic        cfg_wen,
	input  wire logic [3:0]  cfg_wdata,
	// command channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] tag_id,
	input  wire logic [15:0] amount,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       result_kind,
	output logic [15:0]      out_tag_id,
	output logic [15:0]      out_count,
	output logic             last
);

	logic [3:0]         resend_credit_q;
	logic               q_valid;
	logic               q_pop;
	tctr_pkg::item_t    q_item;
	tctr_pkg::result_t  out_res;

	// credit loaded into a slot on each count change and on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resend_credit_q <= tctr_pkg::CREDIT_RST;
		end else if (cfg_wen) begin
			resend_credit_q <= cfg_wdata;
		end
	end

	// decode and queue each transfer
	tctr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.tag_id   (tag_id),
		.amount   (amount),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// slot table scan and result generation
	tctr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.resend_credit (resend_credit_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_res       (out_res)
	);

	assign result_kind = out_res.kind;
	assign out_tag_id  = out_res.tag_id;
	assign out_count   = out_res.count;
	assign last        = out_res.last;

endmodule
`default_nettype wire
